// ----- rtl/afk_pkg.sv -----
// ----------------------------------------------------------------------------
// afk_pkg: shared types and constants for the arm forward kinematics block
// Angle formats, CORDIC tables, lane records and output saturation.
// ----------------------------------------------------------------------------
`default_nettype none

package afk_pkg;

  // Angle input format: degrees with seven fractional bits.
  localparam int ANGLE_FRAC_BITS = 7;
  localparam int FULL_TURN_DEG   = 360 << ANGLE_FRAC_BITS;
  localparam int RIGHT_ANGLE_DEG = 90 << ANGLE_FRAC_BITS;

  // Conversion of a reduced angle r to a 32-bit binary angle:
  // (r * 2^(32-F) + 180) / 360 = (r * 2^(29-F) + 22) / 45, split as
  // r = 45q + m into q * 2^(29-F) plus a small table indexed by m.
  localparam int TURN_SHIFT  = 29 - ANGLE_FRAC_BITS;
  localparam int DIV45_MUL   = 93207;
  localparam int DIV45_SHIFT = 22;
  localparam int FRAC_W      = TURN_SHIFT;

  function automatic logic [45*FRAC_W-1:0] build_frac_tab();
    logic [45*FRAC_W-1:0] t;
    t = '0;
    for (int m = 0; m < 45; m++) begin
      t[m*FRAC_W +: FRAC_W] = FRAC_W'(((longint'(m) << TURN_SHIFT) + 64'd22) / 45);
    end
    return t;
  endfunction

  localparam logic [45*FRAC_W-1:0] FRAC_TAB = build_frac_tab();

  // CORDIC constants, Q30 gain and arctangents in binary angle units.
  localparam int ATAN_LEN = 24;
  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

  function automatic logic signed [33:0] atan_turn(int i);
    logic signed [33:0] a;
    case (i)
      0:  a = 34'sd536870912;
      1:  a = 34'sd316933406;
      2:  a = 34'sd167458907;
      3:  a = 34'sd85004756;
      4:  a = 34'sd42667331;
      5:  a = 34'sd21354465;
      6:  a = 34'sd10679838;
      7:  a = 34'sd5340245;
      8:  a = 34'sd2670163;
      9:  a = 34'sd1335087;
      10: a = 34'sd667544;
      11: a = 34'sd333772;
      12: a = 34'sd166886;
      13: a = 34'sd83443;
      14: a = 34'sd41722;
      15: a = 34'sd20861;
      16: a = 34'sd10430;
      17: a = 34'sd5215;
      18: a = 34'sd2608;
      19: a = 34'sd1304;
      20: a = 34'sd652;
      21: a = 34'sd326;
      22: a = 34'sd163;
      23: a = 34'sd81;
      default: a = '0;
    endcase
    return a;
  endfunction

  // Lane order inside the rotation pipeline.
  localparam int LANE_BASE     = 0;
  localparam int LANE_SHOULDER = 1;
  localparam int LANE_WRIST    = 2;

  // Configuration register indexes.
  localparam logic [1:0] REG_BASE_HEIGHT   = 2'd0;
  localparam logic [1:0] REG_UPPER_ARM     = 2'd1;
  localparam logic [1:0] REG_FOREARM       = 2'd2;
  localparam logic [1:0] REG_GRIPPER       = 2'd3;

  localparam logic [7:0] RST_BASE_HEIGHT = 8'd6;
  localparam logic [7:0] RST_UPPER_ARM   = 8'd8;
  localparam logic [7:0] RST_FOREARM     = 8'd8;
  localparam logic [7:0] RST_GRIPPER     = 8'd6;

  localparam int OUT_LIMIT = 196608;

  // One CORDIC lane: vector, residual angle and the half-turn fold flag.
  typedef struct packed {
    logic signed [33:0] x;
    logic signed [33:0] y;
    logic signed [33:0] z;
    logic               flip;
  } rot_t;

  // Link lengths from the configuration registers.
  typedef struct packed {
    logic [7:0] l1;
    logic [7:0] l2;
    logic [7:0] l3;
    logic [7:0] l4;
  } link_len_t;

  // Wraps a signed angle into [0, 360) degrees.
  function automatic logic [15:0] wrap_deg(logic signed [18:0] a);
    logic signed [20:0] t;
    logic [15:0] r;
    r = '0;
    for (int k = -4; k <= 4; k++) begin
      t = 21'(a) - 21'(k * FULL_TURN_DEG);
      if (t >= 0 && t < FULL_TURN_DEG) begin
        r = t[15:0];
      end
    end
    return r;
  endfunction

  // Clamps a result to the output range.
  function automatic logic [18:0] sat_out(logic signed [31:0] v);
    logic [18:0] r;
    if (v > OUT_LIMIT) begin
      r = 19'(OUT_LIMIT);
    end else if (v < -OUT_LIMIT) begin
      r = 19'(-OUT_LIMIT);
    end else begin
      r = v[18:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/afk_in_if.sv -----
// ----------------------------------------------------------------------------
// afk_in_if: joint angle channel
// Valid/ready channel that carries the three joint angles of one pose.
// ----------------------------------------------------------------------------
`default_nettype none

interface afk_in_if;
  logic               valid;
  logic               ready;
  logic signed [16:0] base_angle;
  logic signed [16:0] shoulder_angle;
  logic signed [16:0] elbow_angle;

  modport source (output valid, output base_angle, output shoulder_angle,
                  output elbow_angle, input ready);
  modport sink   (input valid, input base_angle, input shoulder_angle,
                  input elbow_angle, output ready);
endinterface

`default_nettype wire

// ----- rtl/afk_out_if.sv -----
// ----------------------------------------------------------------------------
// afk_out_if: gripper position channel
// Valid/ready channel that carries the gripper coordinates of one pose.
// ----------------------------------------------------------------------------
`default_nettype none

interface afk_out_if;
  logic               valid;
  logic               ready;
  logic signed [18:0] pos_x;
  logic signed [18:0] pos_y;
  logic signed [18:0] pos_z;

  modport source (output valid, output pos_x, output pos_y, output pos_z,
                  input ready);
  modport sink   (input valid, input pos_x, input pos_y, input pos_z,
                  output ready);
endinterface

`default_nettype wire

// ----- rtl/arm_forward_kinematics_top.sv -----
// ----------------------------------------------------------------------------
// arm_forward_kinematics_top: three-joint arm forward kinematics
// Gripper position from base, shoulder and elbow angles and four link lengths.
// ----------------------------------------------------------------------------
//  Channel   Direction  Payload
//  in_ch     sink       base_angle, shoulder_angle, elbow_angle (17b signed)
//  out_ch    source     pos_x, pos_y, pos_z (19b signed, Q8)
//  cfg_*     write      cfg_idx selects one of four 8-bit link lengths
//
//  One pose is taken every cycle while the skid register is empty; a pose
//  passes three angle stages, one stage per CORDIC rotation, five combine
//  stages and the output register.
//  Reset is synchronous, clears the valid bits and loads the link lengths
//  with their reset values.
//  A stall at the output parks one result in the skid register; in_ch.ready
//  drops in the following cycle and the whole pipeline holds.
// ----------------------------------------------------------------------------
`default_nettype none

module arm_forward_kinematics_top import afk_pkg::*; #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic        clk,
  input  logic        rst,
  afk_in_if.sink      in_ch,
  afk_out_if.source   out_ch,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_idx,
  input  logic [7:0]  cfg_data
);

  link_len_t  links;
  logic       en;
  logic       ang_valid, rot_valid, pipe_valid;
  rot_t [2:0] ang_lane, rot_lane;
  logic [18:0] px, py, pz;
  logic       skid_valid;
  logic [18:0] skid_x, skid_y, skid_z;
  logic       take;

  // Link length registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      links.l1 <= RST_BASE_HEIGHT;
      links.l2 <= RST_UPPER_ARM;
      links.l3 <= RST_FOREARM;
      links.l4 <= RST_GRIPPER;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_BASE_HEIGHT: links.l1 <= cfg_data;
        REG_UPPER_ARM:   links.l2 <= cfg_data;
        REG_FOREARM:     links.l3 <= cfg_data;
        REG_GRIPPER:     links.l4 <= cfg_data;
        default: ;
      endcase
    end
  end

  // The pipeline moves whenever the skid register is free.
  assign en          = !skid_valid;
  assign in_ch.ready = !skid_valid;
  assign take        = out_ch.valid && out_ch.ready;

  afk_angle u_angle (
    .clk            (clk),
    .rst            (rst),
    .en             (en),
    .in_valid       (in_ch.valid),
    .base_angle     (in_ch.base_angle),
    .shoulder_angle (in_ch.shoulder_angle),
    .elbow_angle    (in_ch.elbow_angle),
    .out_valid      (ang_valid),
    .out_lane       (ang_lane)
  );

  afk_cordic #(
    .STAGES (CORDIC_STAGES)
  ) u_cordic (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (ang_valid),
    .in_lane   (ang_lane),
    .out_valid (rot_valid),
    .out_lane  (rot_lane)
  );

  afk_combine u_combine (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .links     (links),
    .in_valid  (rot_valid),
    .in_lane   (rot_lane),
    .out_valid (pipe_valid),
    .pos_x     (px),
    .pos_y     (py),
    .pos_z     (pz)
  );

  // Output register with a skid stage behind it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else if (skid_valid) begin
      if (take) begin
        skid_valid <= 1'b0;
      end
    end else if (!out_ch.valid || take) begin
      out_ch.valid <= pipe_valid;
    end else if (pipe_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (take) begin
        out_ch.pos_x <= skid_x;
        out_ch.pos_y <= skid_y;
        out_ch.pos_z <= skid_z;
      end
    end else if (!out_ch.valid || take) begin
      out_ch.pos_x <= px;
      out_ch.pos_y <= py;
      out_ch.pos_z <= pz;
    end else begin
      skid_x <= px;
      skid_y <= py;
      skid_z <= pz;
    end
  end

`ifndef SYNTHESIS
  // The skid register only holds a result behind a full output register.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_ch.valid)
    else $error("skid register full while output register empty");

  // The skid register fills only on a stalled output.
  a_skid_fill: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_valid) |-> $past(out_ch.valid && !out_ch.ready))
    else $error("skid register filled without an output stall");

  // A base height write lands in the register.
  a_cfg_write: assert property (@(posedge clk) disable iff (rst)
    (cfg_we && cfg_idx == REG_BASE_HEIGHT) |=> links.l1 == $past(cfg_data))
    else $error("base height write lost");
`endif

endmodule

`default_nettype wire

// ----- rtl/afk_angle.sv -----
// ----------------------------------------------------------------------------
// afk_angle: angle preparation pipeline
// Forms the wrist angle, wraps all three angles, converts them to binary
// angles and folds them into the CORDIC convergence range (three stages).
// ----------------------------------------------------------------------------
`default_nettype none

module afk_angle import afk_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_valid,
  input  logic signed [16:0] base_angle,
  input  logic signed [16:0] shoulder_angle,
  input  logic signed [16:0] elbow_angle,
  output logic               out_valid,
  output rot_t [2:0]         out_lane
);

  logic        v1, v2;
  logic [15:0] r1 [3];
  logic [15:0] r2 [3];
  logic [10:0] q2 [3];
  logic signed [18:0] wrist;

  // Stage one: wrist angle and wrap into one turn.
  assign wrist = 19'(RIGHT_ANGLE_DEG) + 19'(shoulder_angle) + 19'(elbow_angle);

  always_ff @(posedge clk) begin
    if (en) begin
      r1[LANE_BASE]     <= wrap_deg(19'(base_angle));
      r1[LANE_SHOULDER] <= wrap_deg(19'(shoulder_angle));
      r1[LANE_WRIST]    <= wrap_deg(wrist);
    end
  end

  // Stage two: quotient by 45 through a reciprocal multiply.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < 3; l++) begin
        q2[l] <= 11'((34'(r1[l]) * 34'(DIV45_MUL)) >> DIV45_SHIFT);
        r2[l] <= r1[l];
      end
    end
  end

  // Stage three: binary angle, fold and CORDIC start vector.
  always_ff @(posedge clk) begin
    logic [5:0]  m;
    logic [31:0] ang;
    if (en) begin
      for (int l = 0; l < 3; l++) begin
        m   = 6'(r2[l] - 16'(q2[l]) * 16'd45);
        ang = 32'({21'(q2[l]), FRAC_W'(0)} + 32'(FRAC_TAB[m*FRAC_W +: FRAC_W]));
        out_lane[l].flip <= ang[31] ^ ang[30];
        if (ang[31] ^ ang[30]) begin
          ang = ang ^ 32'h8000_0000;
        end
        out_lane[l].z <= 34'($signed(ang));
        out_lane[l].x <= CORDIC_GAIN;
        out_lane[l].y <= '0;
      end
    end
  end

  // Valid bits follow the data.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1        <= in_valid;
      v2        <= v1;
      out_valid <= v2;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/afk_cordic.sv -----
// ----------------------------------------------------------------------------
// afk_cordic: three-lane rotation CORDIC
// One micro-rotation per register stage for the base, shoulder and wrist
// angles side by side.
// ----------------------------------------------------------------------------
`default_nettype none

module afk_cordic import afk_pkg::*; #(
  parameter int STAGES = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       en,
  input  logic       in_valid,
  input  rot_t [2:0] in_lane,
  output logic       out_valid,
  output rot_t [2:0] out_lane
);

  localparam int NSTG = (STAGES > ATAN_LEN) ? ATAN_LEN : STAGES;

  rot_t [2:0] pipe [NSTG+1];
  logic       vld  [NSTG+1];

  assign pipe[0] = in_lane;
  assign vld[0]  = in_valid;

  for (genvar i = 0; i < NSTG; i++) begin : g_stage
    localparam logic signed [33:0] ANG = atan_turn(i);
    rot_t [2:0] nxt;

    // Rotate towards zero residual angle.
    always_comb begin
      logic signed [33:0] dx, dy;
      for (int l = 0; l < 3; l++) begin
        dx     = $signed(pipe[i][l].y) >>> i;
        dy     = $signed(pipe[i][l].x) >>> i;
        nxt[l] = pipe[i][l];
        if (!pipe[i][l].z[33]) begin
          nxt[l].x = $signed(pipe[i][l].x) - dx;
          nxt[l].y = $signed(pipe[i][l].y) + dy;
          nxt[l].z = $signed(pipe[i][l].z) - ANG;
        end else begin
          nxt[l].x = $signed(pipe[i][l].x) + dx;
          nxt[l].y = $signed(pipe[i][l].y) - dy;
          nxt[l].z = $signed(pipe[i][l].z) + ANG;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        pipe[i+1] <= nxt;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (en) begin
        vld[i+1] <= vld[i];
      end
    end
  end

  assign out_valid = vld[NSTG];
  assign out_lane  = pipe[NSTG];

endmodule

`default_nettype wire

// ----- rtl/afk_combine.sv -----
// ----------------------------------------------------------------------------
// afk_combine: kinematic combination pipeline
// Weights sines and cosines by the link lengths, forms reach and height,
// projects reach onto the base plane and rounds and clamps (five stages).
// ----------------------------------------------------------------------------
`default_nettype none

module afk_combine import afk_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  link_len_t   links,
  input  logic        in_valid,
  input  rot_t [2:0]  in_lane,
  output logic        out_valid,
  output logic [18:0] pos_x,
  output logic [18:0] pos_y,
  output logic [18:0] pos_z
);

  logic [3:0] vld;

  logic signed [33:0] cos1, sin1, cos2, sin2, cos6, sin6;
  logic signed [33:0] cos1_b, sin1_b, cos1_c, sin1_c;
  logic signed [42:0] pa, pb, pc, pd;
  logic signed [27:0] reach16;
  logic [18:0]        pz_c, pz_d;
  logic signed [59:0] prod_x, prod_y;

  // Stage one: undo the half-turn fold.
  always_ff @(posedge clk) begin
    if (en) begin
      cos1 <= in_lane[LANE_BASE].flip     ? -in_lane[LANE_BASE].x     : in_lane[LANE_BASE].x;
      sin1 <= in_lane[LANE_BASE].flip     ? -in_lane[LANE_BASE].y     : in_lane[LANE_BASE].y;
      cos2 <= in_lane[LANE_SHOULDER].flip ? -in_lane[LANE_SHOULDER].x : in_lane[LANE_SHOULDER].x;
      sin2 <= in_lane[LANE_SHOULDER].flip ? -in_lane[LANE_SHOULDER].y : in_lane[LANE_SHOULDER].y;
      cos6 <= in_lane[LANE_WRIST].flip    ? -in_lane[LANE_WRIST].x    : in_lane[LANE_WRIST].x;
      sin6 <= in_lane[LANE_WRIST].flip    ? -in_lane[LANE_WRIST].y    : in_lane[LANE_WRIST].y;
    end
  end

  // Stage two: link length products, formed at full width.
  always_ff @(posedge clk) begin
    if (en) begin
      pa     <= $signed({35'd0, links.l2}) * 43'(cos2);
      pb     <= $signed({35'd0, links.l3}) * 43'(sin6);
      pc     <= $signed({35'd0, links.l2}) * 43'(sin2);
      pd     <= $signed({35'd0, links.l3}) * 43'(cos6);
      cos1_b <= cos1;
      sin1_b <= sin1;
    end
  end

  // Stage three: reach in Q16 and height rounded to Q8.
  always_ff @(posedge clk) begin
    logic signed [43:0] reach30, z30;
    if (en) begin
      reach30 = 44'(pa) + 44'(pb) + $signed({6'd0, links.l4, 30'd0});
      z30     = $signed({6'd0, links.l1, 30'd0}) + 44'(pc) - 44'(pd);
      reach16 <= 28'((reach30 + 44'sd8192) >>> 14);
      pz_c    <= sat_out(32'((z30 + 44'sd2097152) >>> 22));
      cos1_c  <= cos1_b;
      sin1_c  <= sin1_b;
    end
  end

  // Stage four: projection of the reach onto x and y.
  always_ff @(posedge clk) begin
    if (en) begin
      prod_x <= 60'(reach16) * 60'($signed(cos1_c[31:0]));
      prod_y <= 60'(reach16) * 60'($signed(sin1_c[31:0]));
      pz_d   <= pz_c;
    end
  end

  // Stage five: rounding to Q8 and clamping.
  always_ff @(posedge clk) begin
    if (en) begin
      pos_x <= sat_out(32'((prod_x + (60'sd1 <<< 37)) >>> 38));
      pos_y <= sat_out(32'((prod_y + (60'sd1 <<< 37)) >>> 38));
      pos_z <= pz_d;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      out_valid <= 1'b0;
    end else if (en) begin
      vld       <= {vld[2:0], in_valid};
      out_valid <= vld[3];
    end
  end

endmodule

`default_nettype wire
